### rtl/core/spdcmd_pkg.sv
// shared constants and types of the speed command line parser
`default_nettype none

package spdcmd_pkg;

  // default line buffer depth
  localparam int unsigned LineDepth = 15;

  // ascii codes
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChS     = 8'h73;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;

  // byte positions inside a line
  localparam int unsigned PosS     = 0;
  localparam int unsigned PosP     = 1;
  localparam int unsigned PosD     = 2;
  localparam int unsigned PosSign  = 4;
  localparam int unsigned PosDigit = 5;

  // result widths
  localparam int unsigned RpmW      = 33;
  localparam int unsigned SetpointW = 45;

  // 2*pi/60 in q.32
  localparam int unsigned KW = 29;
  localparam logic [KW-1:0] RpmToRadQ32 = 29'd449767923;

  // fixed point scaling of the product
  localparam int unsigned FracShift = 16;

  typedef logic signed [RpmW-1:0]      rpm_t;
  typedef logic signed [SetpointW-1:0] setpoint_t;

endpackage

`default_nettype wire

### rtl/core/spdcmd_scale.sv
// multi-cycle rpm to rad/s scaling unit, signed q.16 with rounding half away from zero
`default_nettype none

module spdcmd_scale (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start_i,
  input  spdcmd_pkg::rpm_t       rpm_i,
  output logic                   done_o,
  output spdcmd_pkg::setpoint_t  setpoint_o
);

  localparam int unsigned MagW = spdcmd_pkg::RpmW;
  localparam int unsigned LoW  = spdcmd_pkg::FracShift;
  localparam int unsigned HiW  = MagW - LoW;
  localparam int unsigned PloW = LoW + spdcmd_pkg::KW;
  localparam int unsigned PhiW = HiW + spdcmd_pkg::KW;
  localparam int unsigned SpW  = spdcmd_pkg::SetpointW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAG  = 3'd1;
  localparam logic [2:0] S_LO   = 3'd2;
  localparam logic [2:0] S_HI   = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic            done_q, done_d;
  logic            neg_q;
  logic [MagW-1:0] rpm_q;
  logic [MagW-1:0] mag_q;
  logic [PloW-1:0] p_lo_q, p_lo_d;
  logic [PhiW-1:0] p_hi_q, p_hi_d;
  logic [PloW-1:0] lo_rnd;
  logic [PhiW-1:0] q_sum;
  logic [SpW-1:0]  q_mag;
  logic [SpW-1:0]  sp_q, sp_d;

  always_comb begin
    p_lo_d = PloW'(mag_q[LoW-1:0]) * PloW'(spdcmd_pkg::RpmToRadQ32);
    p_hi_d = PhiW'(mag_q[MagW-1:LoW]) * PhiW'(spdcmd_pkg::RpmToRadQ32);
    lo_rnd = p_lo_q + PloW'(1 << (LoW - 1));
    q_sum  = p_hi_q + PhiW'(lo_rnd >> LoW);
    q_mag  = q_sum[SpW-1:0];
    sp_d   = neg_q ? (SpW'(0) - q_mag) : q_mag;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_MAG;
      S_MAG:  state_d = S_LO;
      S_LO:   state_d = S_HI;
      S_HI:   state_d = S_SUM;
      S_SUM: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      rpm_q <= rpm_i;
      neg_q <= rpm_i[MagW-1];
    end
    if (state_q == S_MAG) mag_q <= neg_q ? (MagW'(0) - rpm_q) : rpm_q;
    if (state_q == S_LO)  p_lo_q <= p_lo_d;
    if (state_q == S_HI)  p_hi_q <= p_hi_d;
    if (state_q == S_SUM) sp_q <= sp_d;
  end

  assign done_o     = done_q;
  assign setpoint_o = sp_q;

endmodule

`default_nettype wire

### rtl/core/speed_command_line_parser_core.sv
// speed command line parser: line buffer memory, digit sequencer and setpoint output
// result path: a cr lf ending an "spd" line starts a sweep of the buffer read port
//   (one byte per cycle, registered read), then the sign step, the scaling unit and
//   the output register
// throughput: one byte per cycle between line ends; input stalls while a line is parsed
// reset: write position and all control clear at once; buffer contents stay undefined
`default_nettype none

module speed_command_line_parser_core #(
  parameter int unsigned LINE_DEPTH = spdcmd_pkg::LineDepth
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  [7:0]             rx_byte_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output spdcmd_pkg::rpm_t       speed_rpm_value_o,
  output spdcmd_pkg::setpoint_t  speed_setpoint_o
);

  localparam int unsigned IdxW = $clog2(LINE_DEPTH);
  localparam int unsigned RpmW = spdcmd_pkg::RpmW;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_SIGN  = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_q, state_d;

  // line buffer, one write and one registered read port
  logic [7:0] line_mem [LINE_DEPTH];

  logic [IdxW-1:0] idx_q, idx_d;       // next write position
  logic            prev_cr_q;          // last written byte was a cr
  logic [IdxW-1:0] last_q, last_d;     // last buffer position to read, byte before the cr
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_tag_q;
  logic [7:0]      rd_data_q;

  logic            match_q, match_d;   // line starts with "spd"
  logic            neg_q, neg_d;       // minus sign at byte 4
  logic [RpmW-1:0] acc_q, acc_d;       // digit accumulator, modulo 2^33
  logic [RpmW-1:0] rpm_d;
  logic [RpmW-1:0] rpm_q;

  logic            in_acc;
  logic            line_end;
  logic            parse_start;
  logic            read_done;
  logic [7:0]      digit;

  logic            scale_done;
  spdcmd_pkg::setpoint_t scale_sp;

  logic            out_vld_q, out_vld_d;
  logic            out_load;
  logic [RpmW-1:0] out_rpm_q;
  spdcmd_pkg::setpoint_t out_sp_q;

  // ---------------------------------------------------------------------------
  // byte intake: write at the current position, find cr lf line ends
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // a lf at position 0 never ends a line: the cr would sit at position -1
  assign line_end    = in_acc && (idx_q != '0) && prev_cr_q && (rx_byte_i == spdcmd_pkg::ChLf);
  // lines shorter than five bytes cannot start with "spd" and end in cr lf
  assign parse_start = line_end && (idx_q >= IdxW'(spdcmd_pkg::PosSign));

  always_comb begin
    idx_d = idx_q;
    if (in_acc) begin
      if (line_end || idx_q == IdxW'(LINE_DEPTH - 1)) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) line_mem[idx_q] <= rx_byte_i;
  end

  // ---------------------------------------------------------------------------
  // parse sweep: read positions 0 up to the byte before the cr
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    rd_data_q <= line_mem[rd_ptr_q];
    rd_tag_q  <= rd_ptr_q;
  end

  // digit value is the byte minus '0' in 8 bit two's complement
  assign digit     = rd_data_q - spdcmd_pkg::ChZero;
  assign read_done = rd_vld_q && (rd_tag_q == last_q);

  always_comb begin
    match_d = match_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (rd_vld_q) begin
      if (rd_tag_q == IdxW'(spdcmd_pkg::PosS)) begin
        match_d = match_q && (rd_data_q == spdcmd_pkg::ChS);
      end
      if (rd_tag_q == IdxW'(spdcmd_pkg::PosP)) begin
        match_d = match_q && (rd_data_q == spdcmd_pkg::ChP);
      end
      if (rd_tag_q == IdxW'(spdcmd_pkg::PosD)) begin
        match_d = match_q && (rd_data_q == spdcmd_pkg::ChD);
      end
      if (rd_tag_q == IdxW'(spdcmd_pkg::PosSign)) begin
        neg_d = (rd_data_q == spdcmd_pkg::ChMinus);
      end
      // most significant digit first: acc * 10 + digit
      if (rd_tag_q >= IdxW'(spdcmd_pkg::PosDigit)) begin
        acc_d = (acc_q << 3) + (acc_q << 1) + {{(RpmW - 8){digit[7]}}, digit};
      end
    end
    if (parse_start) begin
      match_d = 1'b1;
      neg_d   = 1'b0;
      acc_d   = '0;
    end
  end

  assign rd_ptr_d = parse_start ? '0 : (state_q == ST_READ ? rd_ptr_q + IdxW'(1) : rd_ptr_q);
  assign last_d   = parse_start ? idx_q - IdxW'(2) : last_q;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign rpm_d    = neg_q ? (RpmW'(0) - acc_q) : acc_q;
  assign out_load = (state_q == ST_OUT) && (!out_vld_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (parse_start) state_d = ST_READ;
      ST_READ:  if (read_done) state_d = match_d ? ST_SIGN : ST_IDLE;
      ST_SIGN:  state_d = ST_SCALE;
      ST_SCALE: if (scale_done) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  spdcmd_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_SIGN),
    .rpm_i      (rpm_d),
    .done_o     (scale_done),
    .setpoint_o (scale_sp)
  );

  // output register, taken while the intake runs on
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ready_i) out_vld_d = 1'b0;
    if (out_load)    out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      prev_cr_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      if (in_acc) prev_cr_q <= (rx_byte_i == spdcmd_pkg::ChCr);
      rd_vld_q  <= (state_q == ST_READ) && (rd_ptr_q <= last_q) && !read_done;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    last_q   <= last_d;
    match_q  <= match_d;
    neg_q    <= neg_d;
    acc_q    <= acc_d;
    if (state_q == ST_SIGN) rpm_q <= rpm_d;
    if (out_load) begin
      out_rpm_q <= rpm_q;
      out_sp_q  <= scale_sp;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign speed_rpm_value_o = out_rpm_q;
  assign speed_setpoint_o  = out_sp_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, idx_q} < (IdxW + 1)'(LINE_DEPTH))
    else $error("write position out of range");

  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (rd_tag_q <= last_q))
    else $error("buffer read beyond the end of the line");

  a_scale_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_done |-> (state_q == ST_SCALE))
    else $error("scaling unit finished outside the scale step");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result shown without a finished parse");

endmodule

`default_nettype wire
